// File: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, register codes and the inversion power chain for the
// GF(2^255-19) arithmetic unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int LIMB_W = 52;   // limb width on the ports
  localparam int RAD_W  = 51;   // radix 2^51
  localparam int ACC_W  = 128;  // column accumulator width
  localparam int WORD_W = 64;   // carry arithmetic width

  typedef logic [4:0][LIMB_W-1:0] elem_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LIMB_W-1:0] a_limb0;
    logic [LIMB_W-1:0] a_limb1;
    logic [LIMB_W-1:0] a_limb2;
    logic [LIMB_W-1:0] a_limb3;
    logic [LIMB_W-1:0] a_limb4;
    logic [LIMB_W-1:0] b_limb0;
    logic [LIMB_W-1:0] b_limb1;
    logic [LIMB_W-1:0] b_limb2;
    logic [LIMB_W-1:0] b_limb3;
    logic [LIMB_W-1:0] b_limb4;
  } in_word_t;

  typedef struct packed {
    logic [LIMB_W-1:0] res_limb0;
    logic [LIMB_W-1:0] res_limb1;
    logic [LIMB_W-1:0] res_limb2;
    logic [LIMB_W-1:0] res_limb3;
    logic [LIMB_W-1:0] res_limb4;
  } out_word_t;

  // Operation modes
  localparam logic [1:0] MODE_MUL   = 2'd0;
  localparam logic [1:0] MODE_SQR   = 2'd1;
  localparam logic [1:0] MODE_INV   = 2'd2;
  localparam logic [1:0] MODE_CANON = 2'd3;

  // Operand slots of the scratch file
  localparam logic [2:0] R_A   = 3'd0;
  localparam logic [2:0] R_B   = 3'd1;
  localparam logic [2:0] R_E2  = 3'd2;
  localparam logic [2:0] R_E11 = 3'd3;
  localparam logic [2:0] R_X   = 3'd4;
  localparam logic [2:0] R_Y   = 3'd5;
  localparam logic [2:0] R_Z   = 3'd6;

  // One chain op: dst = s1*s2, then (cnt-1) more squarings of dst
  typedef struct packed {
    logic [2:0] dst;
    logic [2:0] s1;
    logic [2:0] s2;
    logic [6:0] cnt;
  } op_t;

  localparam logic [4:0] INV_LAST = 5'd21;

  localparam op_t OP_MUL = '{dst: R_X, s1: R_A, s2: R_B, cnt: 7'd1};
  localparam op_t OP_SQR = '{dst: R_X, s1: R_A, s2: R_A, cnt: 7'd1};

  // Exponent p-2 = 2^255-21: 254 squarings, 11 multiplications
  function automatic op_t inv_op(input logic [4:0] pc);
    op_t o;
    case (pc)
      5'd0:    o = '{R_E2,  R_A,   R_A,   7'd1};
      5'd1:    o = '{R_X,   R_E2,  R_E2,  7'd2};
      5'd2:    o = '{R_X,   R_A,   R_X,   7'd1};
      5'd3:    o = '{R_E11, R_E2,  R_X,   7'd1};
      5'd4:    o = '{R_Y,   R_E11, R_E11, 7'd1};
      5'd5:    o = '{R_X,   R_X,   R_Y,   7'd1};
      5'd6:    o = '{R_Y,   R_X,   R_X,   7'd5};
      5'd7:    o = '{R_X,   R_Y,   R_X,   7'd1};
      5'd8:    o = '{R_Y,   R_X,   R_X,   7'd10};
      5'd9:    o = '{R_Y,   R_Y,   R_X,   7'd1};
      5'd10:   o = '{R_Z,   R_Y,   R_Y,   7'd20};
      5'd11:   o = '{R_Y,   R_Z,   R_Y,   7'd1};
      5'd12:   o = '{R_Y,   R_Y,   R_Y,   7'd10};
      5'd13:   o = '{R_X,   R_Y,   R_X,   7'd1};
      5'd14:   o = '{R_Y,   R_X,   R_X,   7'd50};
      5'd15:   o = '{R_Y,   R_Y,   R_X,   7'd1};
      5'd16:   o = '{R_Z,   R_Y,   R_Y,   7'd100};
      5'd17:   o = '{R_Y,   R_Z,   R_Y,   7'd1};
      5'd18:   o = '{R_Y,   R_Y,   R_Y,   7'd50};
      5'd19:   o = '{R_X,   R_Y,   R_X,   7'd1};
      5'd20:   o = '{R_X,   R_X,   R_X,   7'd5};
      5'd21:   o = '{R_X,   R_X,   R_E11, 7'd1};
      default: o = '{R_X,   R_X,   R_X,   7'd1};
    endcase
    return o;
  endfunction

endpackage

// File: design/p25519_field_arith_unit.sv
// ----------------------------------------------------------------------------
// p25519_field_arith_unit
// Multiply, square, invert and canonical reduce in GF(2^255-19), radix 2^51.
//
//   channel | direction | signals
//   in      | in        | in_valid, in_stall, in_data
//   out     | out       | out_valid, out_stall, out_data
//
// Multiply and square run the digit steps of the 52x16 multiplier plus the
// serial carry pass. Invert runs 265 such products back to back. Canonical
// reduce runs a serial carry pass, a quotient ripple and a second carry pass.
// One word is in work at a time; the next is taken once the result sits in
// the output register, which holds it for as long as out_stall is high.
// Reset is synchronous and clears the control state only.
// ----------------------------------------------------------------------------
module p25519_field_arith_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfa_pkg::out_word_t out_data
);
  import pfa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_GO    = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_CANON = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state;
  in_word_t               in_r;
  logic [4:0]             pc;
  logic [6:0]             rep;
  logic [4:0]             cstep;
  elem_t                  mem [8];
  elem_t                  rd1, rd2, res_r, ina, inb, mul_res;
  logic                   mul_start, mul_done;
  op_t                    cur;
  logic                   last_op;
  logic [2:0]             ra1, ra2;
  logic [4:0][WORD_W-1:0] v;
  logic [WORD_W-1:0]      cc, cadd, qsum;
  logic [12:0]            q;
  logic                   post;

  assign in_stall  = (state != S_IDLE);
  assign mul_start = (state == S_GO);
  // result moves into the output register
  assign post      = (state == S_DONE) && (!out_valid || !out_stall);

  assign ina = {in_r.a_limb4, in_r.a_limb3, in_r.a_limb2, in_r.a_limb1, in_r.a_limb0};
  assign inb = {in_r.b_limb4, in_r.b_limb3, in_r.b_limb2, in_r.b_limb1, in_r.b_limb0};

  // Current op of the chain
  always_comb begin
    case (in_r.mode)
      MODE_MUL: cur = OP_MUL;
      MODE_SQR: cur = OP_SQR;
      default:  cur = inv_op(pc);
    endcase
    last_op = (in_r.mode != MODE_INV) || (pc == INV_LAST);
    ra1     = (rep == 7'd1) ? cur.s1 : cur.dst;
    ra2     = (rep == 7'd1) ? cur.s2 : cur.dst;
  end

  pfa_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .opa   (rd1),
    .opb   (rd2),
    .done  (mul_done),
    .res   (mul_res)
  );

  // Scratch file: registered reads, input operands bypass the array
  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rd1 <= (ra1 == R_A) ? ina : (ra1 == R_B) ? inb : mem[ra1];
      rd2 <= (ra2 == R_A) ? ina : (ra2 == R_B) ? inb : mem[ra2];
    end
    if (state == S_WAIT && mul_done) begin
      mem[cur.dst] <= mul_res;
    end
  end

  // Canonical reduce step on the rotating limb register
  always_comb begin
    cc   = v[0] >> RAD_W;
    cadd = '0;
    if (cstep < 5'd4) begin
      cadd = cc;
    end else if (cstep == 5'd4) begin
      cadd = (cc << 4) + (cc << 1) + cc;
    end else if (cstep >= 5'd12 && cstep < 5'd16) begin
      cadd = cc;
    end
    qsum = v[0] + ((cstep == 5'd6) ? 64'd19 : {51'b0, q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (post) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            pc   <= 5'd0;
            rep  <= 7'd1;
            if (in_data.mode == MODE_CANON) begin
              v     <= {64'(in_data.a_limb4), 64'(in_data.a_limb3), 64'(in_data.a_limb2),
                        64'(in_data.a_limb1), 64'(in_data.a_limb0)};
              cstep <= 5'd0;
              state <= S_CANON;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD:   state <= S_GO;
        S_GO:   state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            res_r <= mul_res;
            if (rep == cur.cnt) begin
              rep <= 7'd1;
              if (last_op) begin
                state <= S_DONE;
              end else begin
                pc    <= pc + 5'd1;
                state <= S_RD;
              end
            end else begin
              rep   <= rep + 7'd1;
              state <= S_RD;
            end
          end
        end
        S_CANON: begin
          cstep <= cstep + 5'd1;
          if (cstep <= 5'd4 || cstep >= 5'd12) begin
            // carry pass, one limb per cycle
            v <= {{13'b0, v[0][RAD_W-1:0]}, v[4:2], v[1] + cadd};
          end else if (cstep == 5'd5) begin
            v[0] <= {13'b0, v[0][RAD_W-1:0]};
            v[1] <= v[1] + cc;
          end else if (cstep <= 5'd10) begin
            // quotient ripple
            q <= qsum[63:51];
            v <= {v[0], v[4:1]};
          end else begin
            v[0] <= v[0] + (({51'b0, q} << 4) + ({51'b0, q} << 1) + {51'b0, q});
          end
          if (cstep == 5'd16) begin
            res_r <= {v[0][LIMB_W-1:0] & 52'h7FFFFFFFFFFFF, v[4][LIMB_W-1:0],
                      v[3][LIMB_W-1:0], v[2][LIMB_W-1:0], v[1][LIMB_W-1:0]};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (post) begin
            out_data  <= '{res_limb0: res_r[0], res_limb1: res_r[1], res_limb2: res_r[2],
                           res_limb3: res_r[3], res_limb4: res_r[4]};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/pfa_mul.sv
// ----------------------------------------------------------------------------
// pfa_mul
// Digit-serial field multiplier: 16-bit digits of the b limbs against a full
// a limb, column by column, then one serial carry pass with fold by 19.
// ----------------------------------------------------------------------------
module pfa_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pfa_pkg::elem_t opa,
  input  pfa_pkg::elem_t opb,
  output logic          done,
  output pfa_pkg::elem_t res
);
  import pfa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_CARRY = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state;
  logic [2:0]             col, term, step;
  logic [1:0]             dig;
  elem_t                  a_sh, b_sh;
  logic [47:0]            dsh;
  logic [ACC_W-1:0]       acc;
  logic [4:0][ACC_W-1:0]  t;

  logic                   fold;
  logic [56:0]            b57, b19, sel;
  logic [15:0]            digit;
  logic [67:0]            prod;
  logic [ACC_W-1:0]       addend, acc_sum, t0_next;
  logic [WORD_W-1:0]      c64, c19;
  logic [12:0]            fc;

  // Partial product of one a limb and one 16-bit digit
  always_comb begin
    fold    = term > col;
    b57     = {5'b0, b_sh[0]};
    b19     = (b57 << 4) + (b57 << 1) + b57;
    sel     = fold ? b19 : b57;
    digit   = (dig == 2'd0) ? sel[15:0] : dsh[15:0];
    prod    = 68'(a_sh[0]) * 68'(digit);
    addend  = {60'b0, prod} << {dig, 4'b0};
    acc_sum = ((term == 3'd0 && dig == 2'd0) ? '0 : acc) + addend;
  end

  // Carry step on the rotating column file
  always_comb begin
    c64 = t[0][114:51];
    c19 = (c64 << 4) + (c64 << 1) + c64;
    if (step == 3'd4) begin
      t0_next = {64'b0, t[1][WORD_W-1:0] + c19};
    end else begin
      t0_next = t[1] + {64'b0, c64};
    end
    fc = t[0][63:51];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
      case (state)
        ST_IDLE: begin
          if (start) begin
            a_sh  <= opa;
            b_sh  <= opb;
            col   <= 3'd0;
            term  <= 3'd0;
            dig   <= 2'd0;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          acc <= acc_sum;
          dsh <= (dig == 2'd0) ? 48'(sel >> 16) : (dsh >> 16);
          dig <= dig + 2'd1;
          if (dig == 2'd3) begin
            a_sh <= {a_sh[0], a_sh[4:1]};
            if (term == 3'd4) begin
              term <= 3'd0;
              t    <= {acc_sum, t[4:1]};
              if (col == 3'd4) begin
                step  <= 3'd0;
                state <= ST_CARRY;
              end else begin
                col <= col + 3'd1;
              end
            end else begin
              term <= term + 3'd1;
              b_sh <= {b_sh[3:0], b_sh[4]};
            end
          end
        end
        ST_CARRY: begin
          t    <= {{77'b0, t[0][RAD_W-1:0]}, t[4:2], t0_next};
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          t[0]  <= {77'b0, t[0][RAD_W-1:0]};
          t[1]  <= {64'b0, t[1][WORD_W-1:0] + {51'b0, fc}};
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    for (int m = 0; m < 5; m++) begin
      res[m] = t[m][LIMB_W-1:0];
    end
  end

endmodule

// File: design/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the field arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input pfa_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pfa_pkg::out_word_t out_data
);
  import pfa_pkg::*;

  // A taken word keeps the unit busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("unit took a word and did not go busy");

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result appears only from a word in work
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a word in work");

  // Going idle means the result was just posted
  a_post: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) && !$past(rst) |-> out_valid)
    else $error("unit went idle without posting a result");

endmodule

bind p25519_field_arith_unit pfa_checker u_pfa_checker (.*);
